@@ rtl/core/gmd_pkg.sv @@
// Shared types and constants of the Gaussian mixture density core.
package gmd_pkg;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_L_M0, ST_L_M1, ST_L_M2, ST_L_M3, ST_L_M4,
		ST_L_D0, ST_L_D1, ST_L_D2, ST_L_WR,
		ST_E_M0, ST_E_M1, ST_E_RD, ST_E_RDW,
		ST_E_M2, ST_E_M3, ST_E_M4, ST_E_K,
		ST_E_HM, ST_E_HD, ST_E_SH, ST_E_AM, ST_E_ACC, ST_E_OUT
	} state_t;

	// Item actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	// Register index (word address bit)
	localparam logic REG_ACTIVE = 1'b0;

	// (2pi)^-1.5 in Q0.32, ln2 and 63*ln2 in Q.32, 1.0 in Q0.62
	localparam logic [31:0] AMP_K   = 32'd272703090;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [63:0] LN2_63  = 64'd187553801736;
	localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;
	localparam logic [3:0]  HORNER_TERMS = 4'd12;

	// Table entry: {saturated, amplitude, inverse width^2, inverse flattening^2}
	localparam int ENTRY_W = 1 + 64 + 32 + 32;

endpackage

@@ rtl/core/gaussian_mixture_density_core.sv @@
// Load: five products, then up to three bit-serial divisions (128, 49 and 77 steps).
// Evaluate: for each of the N active entries, the twelve Horner steps of exp() each take
// two products; an entry whose exponent is out of range skips them. One item is worked
// on at a time.
// A result waits in an output register while the next item is taken.
// Reset clears control and the register; table entries are undefined until loaded.
module gaussian_mixture_density_core #(
	parameter int MAX_COMPONENTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [3:0]  slot,
	input  logic [31:0] weight,
	input  logic [31:0] width,
	input  logic [30:0] flattening,
	input  logic signed [31:0] radius,
	input  logic signed [31:0] height,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] density_value,
	output logic        overflow,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = MAX_COMPONENTS > 1 ? $clog2(MAX_COMPONENTS) : 1;
	localparam logic [8:0] MAX_C = 9'(MAX_COMPONENTS);

	gmd_pkg::state_t state_q, state_d;

	logic [4:0]  active_q;
	logic        issue_q;
	logic [3:0]  slot_q;
	logic [31:0] weight_q, width_q, rad_q, hgt_q;
	logic [30:0] flat_q;
	logic [63:0] r2_q, z2_q, w2_q, wf_q, f2_q, numprod_q;
	logic [127:0] den_q;
	logic [63:0] amp_q;
	logic        sat_q;
	logic [31:0] iw_q, iq_q;
	logic [80:0] m_q;
	logic [95:0] p1_q;
	logic [37:0] t_q;
	logic [5:0]  k_q;
	logic [61:0] x_q;
	logic [62:0] p_q;
	logic [63:0] y_q, term_q, acc_q;
	logic [3:0]  n_q;
	logic        ovf_q;
	logic [8:0]  idx_q, cnt;
	logic [63:0] dens_q;
	logic        ovfo_q, outv_q;

	logic         mul_start, mul_done, div_start, div_done;
	logic [63:0]  mul_a, mul_b;
	logic [127:0] mul_p, div_num, div_den, div_quot;
	logic [7:0]   div_len;
	logic         ram_we;
	logic [gmd_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [8:0]   slot_ext;
	logic [31:0]  abs_r, abs_z;
	logic [127:0] tsum;
	logic         t_big;
	logic [37:0]  krem;
	logic [5:0]   kval;
	logic [64:0]  acc_sum;
	logic         in_fire, out_load;
	logic [63:0]  rcp_m;
	logic [2:0]   rcp_sh;
	logic [127:0] hq;

	gmd_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .product(mul_p)
	);

	gmd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.len(div_len), .done(div_done), .quot(div_quot)
	);

	gmd_ram #(.WIDTH(gmd_pkg::ENTRY_W), .DEPTH(MAX_COMPONENTS)) u_table (
		.clk(clk), .we(ram_we), .waddr(slot_ext[AW-1:0]), .wdata(ram_wdata),
		.raddr(idx_q[AW-1:0]), .rdata(ram_rdata)
	);

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == gmd_pkg::REG_ACTIVE) ? {27'd0, active_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 5'd0;
		end else if (psel && penable && pwrite && paddr[2] == gmd_pkg::REG_ACTIVE) begin
			active_q <= pwdata[4:0];
		end
	end

	// Helpers
	always_comb begin
		slot_ext = {5'd0, slot_q};
		cnt = ({4'd0, active_q} > MAX_C) ? MAX_C : {4'd0, active_q};
		abs_r = rad_q[31] ? (~rad_q + 32'd1) : rad_q;
		abs_z = hgt_q[31] ? (~hgt_q + 32'd1) : hgt_q;
		tsum = {32'd0, p1_q} + {mul_p[63:0], 64'd0};
		t_big = (tsum[127:81] != '0) || (tsum[80:17] >= gmd_pkg::LN2_63);
		acc_sum = {1'b0, acc_q} + {1'b0, term_q};
		ram_we = (state_q == gmd_pkg::ST_L_WR) && (slot_ext < MAX_C);
		ram_wdata = {sat_q, amp_q, iw_q, iq_q};
		in_fire = in_valid && in_ready;
		out_load = (state_q == gmd_pkg::ST_E_OUT) && (!outv_q || out_ready);
	end

	// Split T into whole ln2 steps and remainder
	always_comb begin
		krem = t_q;
		kval = 6'd0;
		for (int j = 5; j >= 0; j--) begin
			if (krem >= (38'(gmd_pkg::LN2_Q32) << j)) begin
				krem = krem - (38'(gmd_pkg::LN2_Q32) << j);
				kval[j] = 1'b1;
			end
		end
	end

	// Reciprocal of the Horner divisor: floor(y/n) = floor(y*m / 2^(62+sh)) for y < 2^62
	always_comb begin
		unique case (n_q)
			4'd1: begin
				rcp_m = 64'd1 << 62;
				rcp_sh = 3'd0;
			end
			4'd2: begin
				rcp_m = 64'd1 << 62;
				rcp_sh = 3'd1;
			end
			4'd3: begin
				rcp_m = 64'(((128'd1 << 64) + 128'd2) / 128'd3);
				rcp_sh = 3'd2;
			end
			4'd4: begin
				rcp_m = 64'd1 << 62;
				rcp_sh = 3'd2;
			end
			4'd5: begin
				rcp_m = 64'(((128'd1 << 65) + 128'd4) / 128'd5);
				rcp_sh = 3'd3;
			end
			4'd6: begin
				rcp_m = 64'(((128'd1 << 65) + 128'd5) / 128'd6);
				rcp_sh = 3'd3;
			end
			4'd7: begin
				rcp_m = 64'(((128'd1 << 65) + 128'd6) / 128'd7);
				rcp_sh = 3'd3;
			end
			4'd8: begin
				rcp_m = 64'd1 << 62;
				rcp_sh = 3'd3;
			end
			4'd9: begin
				rcp_m = 64'(((128'd1 << 66) + 128'd8) / 128'd9);
				rcp_sh = 3'd4;
			end
			4'd10: begin
				rcp_m = 64'(((128'd1 << 66) + 128'd9) / 128'd10);
				rcp_sh = 3'd4;
			end
			4'd11: begin
				rcp_m = 64'(((128'd1 << 66) + 128'd10) / 128'd11);
				rcp_sh = 3'd4;
			end
			4'd12: begin
				rcp_m = 64'(((128'd1 << 66) + 128'd11) / 128'd12);
				rcp_sh = 3'd4;
			end
			default: begin
				rcp_m = '0;
				rcp_sh = 3'd0;
			end
		endcase
		hq = mul_p >> (7'd62 + {4'd0, rcp_sh});
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmd_pkg::ST_IDLE;
			issue_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) begin
				issue_q <= 1'b1;
			end else if (mul_done || div_done) begin
				issue_q <= 1'b0;
			end
		end
	end

	// Next state and unit operands
	always_comb begin
		state_d = state_q;
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		div_len = 8'd0;
		in_ready = (state_q == gmd_pkg::ST_IDLE);
		unique case (state_q)
			gmd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (action == gmd_pkg::ACT_EVAL) ? gmd_pkg::ST_E_M0
						: gmd_pkg::ST_L_M0;
				end
			end
			gmd_pkg::ST_L_M0: begin
				mul_start = !issue_q;
				mul_a = {32'd0, weight_q};
				mul_b = {32'd0, gmd_pkg::AMP_K};
				if (mul_done) state_d = gmd_pkg::ST_L_M1;
			end
			gmd_pkg::ST_L_M1: begin
				mul_start = !issue_q;
				mul_a = {32'd0, width_q};
				mul_b = {32'd0, width_q};
				if (mul_done) state_d = gmd_pkg::ST_L_M2;
			end
			gmd_pkg::ST_L_M2: begin
				mul_start = !issue_q;
				mul_a = {32'd0, width_q};
				mul_b = {33'd0, flat_q};
				if (mul_done) state_d = gmd_pkg::ST_L_M3;
			end
			gmd_pkg::ST_L_M3: begin
				mul_start = !issue_q;
				mul_a = w2_q;
				mul_b = wf_q;
				if (mul_done) state_d = gmd_pkg::ST_L_M4;
			end
			gmd_pkg::ST_L_M4: begin
				mul_start = !issue_q;
				mul_a = {33'd0, flat_q};
				mul_b = {33'd0, flat_q};
				if (mul_done) state_d = gmd_pkg::ST_L_D0;
			end
			gmd_pkg::ST_L_D0: begin
				div_start = !issue_q;
				div_num = {2'd0, numprod_q, 62'd0};
				div_den = den_q;
				div_len = 8'd128;
				if (div_done) state_d = gmd_pkg::ST_L_D1;
			end
			gmd_pkg::ST_L_D1: begin
				if (w2_q <= 64'd65536) begin
					state_d = gmd_pkg::ST_L_D2;
				end else begin
					div_start = !issue_q;
					div_num = 128'd1 << 48;
					div_den = {64'd0, w2_q};
					div_len = 8'd49;
					if (div_done) state_d = gmd_pkg::ST_L_D2;
				end
			end
			gmd_pkg::ST_L_D2: begin
				if (f2_q <= (64'd1 << 44)) begin
					state_d = gmd_pkg::ST_L_WR;
				end else begin
					div_start = !issue_q;
					div_num = 128'd1 << 76;
					div_den = {64'd0, f2_q};
					div_len = 8'd77;
					if (div_done) state_d = gmd_pkg::ST_L_WR;
				end
			end
			gmd_pkg::ST_L_WR: state_d = gmd_pkg::ST_IDLE;
			gmd_pkg::ST_E_M0: begin
				mul_start = !issue_q;
				mul_a = {32'd0, abs_r};
				mul_b = {32'd0, abs_r};
				if (mul_done) state_d = gmd_pkg::ST_E_M1;
			end
			gmd_pkg::ST_E_M1: begin
				mul_start = !issue_q;
				mul_a = {32'd0, abs_z};
				mul_b = {32'd0, abs_z};
				if (mul_done) begin
					state_d = (cnt == 9'd0) ? gmd_pkg::ST_E_OUT : gmd_pkg::ST_E_RD;
				end
			end
			gmd_pkg::ST_E_RD:  state_d = gmd_pkg::ST_E_RDW;
			gmd_pkg::ST_E_RDW: state_d = gmd_pkg::ST_E_M2;
			gmd_pkg::ST_E_M2: begin
				mul_start = !issue_q;
				mul_a = z2_q;
				mul_b = {32'd0, iq_q};
				if (mul_done) state_d = gmd_pkg::ST_E_M3;
			end
			gmd_pkg::ST_E_M3: begin
				mul_start = !issue_q;
				mul_a = m_q[63:0];
				mul_b = {32'd0, iw_q};
				if (mul_done) state_d = gmd_pkg::ST_E_M4;
			end
			gmd_pkg::ST_E_M4: begin
				mul_start = !issue_q;
				mul_a = {47'd0, m_q[80:64]};
				mul_b = {32'd0, iw_q};
				if (mul_done) state_d = t_big ? gmd_pkg::ST_E_ACC : gmd_pkg::ST_E_K;
			end
			gmd_pkg::ST_E_K: state_d = gmd_pkg::ST_E_HM;
			gmd_pkg::ST_E_HM: begin
				mul_start = !issue_q;
				mul_a = {2'd0, x_q};
				mul_b = {1'b0, p_q};
				if (mul_done) state_d = gmd_pkg::ST_E_HD;
			end
			gmd_pkg::ST_E_HD: begin
				mul_start = !issue_q;
				mul_a = y_q;
				mul_b = rcp_m;
				if (mul_done) begin
					state_d = (n_q == 4'd1) ? gmd_pkg::ST_E_SH : gmd_pkg::ST_E_HM;
				end
			end
			gmd_pkg::ST_E_SH: state_d = gmd_pkg::ST_E_AM;
			gmd_pkg::ST_E_AM: begin
				mul_start = !issue_q;
				mul_a = amp_q;
				mul_b = {1'b0, p_q};
				if (mul_done) state_d = gmd_pkg::ST_E_ACC;
			end
			gmd_pkg::ST_E_ACC: begin
				state_d = (idx_q + 9'd1 == cnt) ? gmd_pkg::ST_E_OUT : gmd_pkg::ST_E_RD;
			end
			gmd_pkg::ST_E_OUT: begin
				if (!outv_q || out_ready) state_d = gmd_pkg::ST_IDLE;
			end
			default: state_d = gmd_pkg::ST_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q <= slot;
			weight_q <= weight;
			width_q <= (width == 32'd0) ? 32'd1 : width;
			flat_q <= (flattening == 31'd0) ? 31'd1 : flattening;
			rad_q <= radius;
			hgt_q <= height;
		end
		unique case (state_q)
			gmd_pkg::ST_L_M0: if (mul_done) numprod_q <= mul_p[63:0];
			gmd_pkg::ST_L_M1: if (mul_done) w2_q <= mul_p[63:0];
			gmd_pkg::ST_L_M2: if (mul_done) wf_q <= mul_p[63:0];
			gmd_pkg::ST_L_M3: if (mul_done) den_q <= mul_p;
			gmd_pkg::ST_L_M4: if (mul_done) f2_q <= mul_p[63:0];
			gmd_pkg::ST_L_D0: begin
				if (div_done) begin
					sat_q <= div_quot[127:64] != '0;
					amp_q <= (div_quot[127:64] != '0) ? '1 : div_quot[63:0];
				end
			end
			gmd_pkg::ST_L_D1: begin
				if (w2_q <= 64'd65536) iw_q <= '1;
				else if (div_done) iw_q <= div_quot[31:0];
			end
			gmd_pkg::ST_L_D2: begin
				if (f2_q <= (64'd1 << 44)) iq_q <= '1;
				else if (div_done) iq_q <= div_quot[31:0];
			end
			gmd_pkg::ST_E_M0: if (mul_done) r2_q <= mul_p[63:0];
			gmd_pkg::ST_E_M1: begin
				if (mul_done) begin
					z2_q <= mul_p[63:0];
					acc_q <= '0;
					ovf_q <= 1'b0;
					idx_q <= 9'd0;
				end
			end
			gmd_pkg::ST_E_RDW: begin
				sat_q <= ram_rdata[128];
				amp_q <= ram_rdata[127:64];
				iw_q <= ram_rdata[63:32];
				iq_q <= ram_rdata[31:0];
			end
			gmd_pkg::ST_E_M2: begin
				if (mul_done) m_q <= {17'd0, r2_q} + {3'd0, mul_p[93:16]};
			end
			gmd_pkg::ST_E_M3: if (mul_done) p1_q <= mul_p[95:0];
			gmd_pkg::ST_E_M4: begin
				if (mul_done) begin
					term_q <= '0;
					t_q <= tsum[54:17];
				end
			end
			gmd_pkg::ST_E_K: begin
				k_q <= kval;
				x_q <= {krem[31:0], 30'd0};
				p_q <= gmd_pkg::ONE_Q62;
				n_q <= gmd_pkg::HORNER_TERMS;
			end
			gmd_pkg::ST_E_HM: if (mul_done) y_q <= mul_p[125:62];
			gmd_pkg::ST_E_HD: begin
				if (mul_done) begin
					p_q <= gmd_pkg::ONE_Q62 - hq[62:0];
					n_q <= n_q - 4'd1;
				end
			end
			gmd_pkg::ST_E_SH: p_q <= p_q >> k_q;
			gmd_pkg::ST_E_AM: if (mul_done) term_q <= mul_p[125:62];
			gmd_pkg::ST_E_ACC: begin
				acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
				ovf_q <= ovf_q | acc_sum[64] | sat_q;
				idx_q <= idx_q + 9'd1;
			end
			default: ;
		endcase
		if (out_load) begin
			dens_q <= acc_q;
			ovfo_q <= ovf_q;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
		end else if (out_load) begin
			outv_q <= 1'b1;
		end else if (out_ready) begin
			outv_q <= 1'b0;
		end
	end

	assign out_valid = outv_q;
	assign density_value = dens_q;
	assign overflow = ovfo_q;

endmodule

@@ rtl/core/gmd_ram.sv @@
// Generic single-port-write, registered-read RAM.
module gmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/gmd_mul.sv @@
// Sequential 64x64 multiplier built from one 32x32 multiplier, accumulating four partial products.
module gmd_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] product
);

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0]   step_q;
	logic         busy_q, done_q;
	logic [31:0]  a_h, b_h;
	logic [63:0]  part;
	logic [127:0] part_sh;
	logic [1:0]   sh;

	// Select partial product halves and its weight
	always_comb begin
		a_h = step_q[1] ? a_q[63:32] : a_q[31:0];
		b_h = step_q[0] ? b_q[63:32] : b_q[31:0];
		part = a_h * b_h;
		sh = 2'({1'b0, step_q[1]} + {1'b0, step_q[0]});
		part_sh = {64'd0, part} << {sh, 5'd0};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulate partial products
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part_sh;
		end
	end

	assign done = done_q;
	assign product = acc_q;

endmodule

@@ rtl/core/gmd_div.sv @@
// Restoring divider, one quotient bit a cycle, 128-bit operands.
module gmd_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [127:0] den,
	input  logic [7:0]   len,
	output logic         done,
	output logic [127:0] quot
);

	logic [127:0] num_q, den_q, quot_q;
	logic [128:0] rem_q;
	logic [7:0]   cnt_q;
	logic         busy_q, done_q;
	logic [128:0] trial;
	logic         ge;
	logic [6:0]   align;

	// Trial subtract
	always_comb begin
		trial = {rem_q[127:0], num_q[127]};
		ge = trial >= {1'b0, den_q};
		align = 7'(8'd128 - len);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 8'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one numerator bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num << align;
			den_q <= den;
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[126:0], 1'b0};
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			quot_q <= {quot_q[126:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
